// File: hw/rtl/hbc_pkg.sv
// hbc_pkg: shared types and constants of the hashed block buffer cache
// no dependencies

package hbc_pkg;

    localparam logic [1:0] KIND_GET     = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_PIN     = 2'd2;
    localparam logic [1:0] KIND_UNPIN   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NO_BUF = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    localparam logic [7:0]  COUNT_MAX   = 8'hff;
    localparam logic [30:0] STAMP_LIMIT = 31'h7fffffff;

    localparam int REM_BITS  = 4;
    localparam int REM_STEPS = 32 / REM_BITS;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  device;
        logic [31:0] block_number;
        logic [4:0]  buffer_index;
        logic [30:0] now;
    } t_req;

    typedef struct packed {
        logic [4:0] entry;
        logic       hit;
        logic       need_read;
        logic [1:0] status;
    } t_rsp;

    typedef struct packed {
        logic [7:0]  device;
        logic [31:0] block;
        logic [5:0]  home;
        logic [7:0]  count;
        logic [30:0] stamp;
        logic        cvalid;
    } t_rec;

    typedef struct packed {
        logic hit;
        logic hit_full;
        logic hit_read;
        logic cand;
    } t_scan;

endpackage

// File: hw/rtl/hbc_store.sv
// hbc_store: entry record memory, one write and one registered read port
// depends on hbc_pkg; entries never written read as zero

module hbc_store #(
    parameter int NUM_BUFFERS = 32,
    parameter int IW          = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IW-1:0]    i_rd_addr,
    output hbc_pkg::t_rec    o_rd_data,
    input  logic             i_wr_en,
    input  logic [IW-1:0]    i_wr_addr,
    input  hbc_pkg::t_rec    i_wr_data
);
    import hbc_pkg::*;

    t_rec                   mem [NUM_BUFFERS];
    logic [NUM_BUFFERS-1:0] r_init;
    t_rec                   r_rd_data;
    logic                   r_rd_live;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init    <= '0;
            r_rd_live <= 1'b0;
        end else begin
            r_rd_live <= r_init[i_rd_addr];
            if (i_wr_en) begin
                r_init[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_live ? r_rd_data : '0;

endmodule

// File: hw/rtl/hbc_scan.sv
// hbc_scan: shared per-entry compare unit, hit test and victim selection
// depends on hbc_pkg; fed one entry record per cycle by the sequencer

module hbc_scan #(
    parameter int NUM_BUCKETS = 13,
    parameter int IW          = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  logic             i_en,
    input  logic [IW-1:0]    i_idx,
    input  hbc_pkg::t_rec    i_rec,
    input  logic [5:0]       i_home,
    input  logic [7:0]       i_device,
    input  logic [31:0]      i_block,
    output hbc_pkg::t_scan   o_flags,
    output logic [IW-1:0]    o_hit_idx,
    output logic [IW-1:0]    o_cand_idx
);
    import hbc_pkg::*;

    logic          r_hit;
    logic          r_hit_full;
    logic          r_hit_read;
    logic [IW-1:0] r_hit_idx;
    logic          r_cand;
    logic [IW-1:0] r_cand_idx;
    logic [36:0]   r_cand_key;

    logic          match;
    logic          cand_ok;
    logic [6:0]    bkt_dist;
    logic [36:0]   key;
    logic          better;

    always_comb begin
        match = (i_rec.home == i_home) && (i_rec.device == i_device)
                && (i_rec.block == i_block);
        cand_ok = (i_rec.count == 8'd0) && (i_rec.stamp != STAMP_LIMIT);
        bkt_dist = {1'b0, i_rec.home} - {1'b0, i_home};
        if (i_rec.home < i_home) begin
            bkt_dist = bkt_dist + 7'(NUM_BUCKETS);
        end
        key    = {bkt_dist[5:0], i_rec.stamp};
        better = !r_cand || (key < r_cand_key);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit  <= 1'b0;
            r_cand <= 1'b0;
        end else if (i_clear) begin
            r_hit  <= 1'b0;
            r_cand <= 1'b0;
        end else if (i_en) begin
            if (match && !r_hit) begin
                r_hit <= 1'b1;
            end
            if (cand_ok && better) begin
                r_cand <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && match && !r_hit) begin
            r_hit_idx  <= i_idx;
            r_hit_full <= (i_rec.count == COUNT_MAX);
            r_hit_read <= !i_rec.cvalid;
        end
        if (i_en && cand_ok && better) begin
            r_cand_idx <= i_idx;
            r_cand_key <= key;
        end
    end

    assign o_flags    = '{hit: r_hit, hit_full: r_hit_full, hit_read: r_hit_read, cand: r_cand};
    assign o_hit_idx  = r_hit_idx;
    assign o_cand_idx = r_cand_idx;

endmodule

// File: hw/rtl/hashed_block_buffer_cache.sv
// hashed_block_buffer_cache: top level, sequencer, bucket remainder and result beat
// depends on hbc_pkg, hbc_store, hbc_scan
// get: result beat after the bucket remainder steps, a scan of every entry
//   through the single read port and a write-back of the chosen entry
// release, pin, unpin: result beat after a single read-modify-write step
// one item at a time; busy is low in the cycle the result beat is shown
// synchronous active-low reset empties all entries; receiver cannot stall

module hashed_block_buffer_cache #(
    parameter int NUM_BUFFERS = 32,
    parameter int NUM_BUCKETS = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  hbc_pkg::t_req i_req,
    output logic          o_strobe,
    output hbc_pkg::t_rsp o_rsp
);
    import hbc_pkg::*;

    localparam int IW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam int CW = $clog2(NUM_BUFFERS + 1);
    localparam int MW = $clog2(REM_STEPS);

    typedef enum logic [2:0] {
        S_IDLE, S_MOD, S_SCAN, S_GETW, S_RMW
    } t_state;

    t_state        r_state, n_state;
    logic          r_busy, n_busy;
    logic          r_strobe, n_strobe;
    t_rsp          r_rsp, n_rsp;
    t_req          r_req, n_req;
    logic [31:0]   r_shift, n_shift;
    logic [5:0]    r_home, n_home;
    logic [MW-1:0] r_mcnt, n_mcnt;
    logic [CW-1:0] r_issue, n_issue;
    logic          r_dv, n_dv;
    logic [IW-1:0] r_didx, n_didx;
    logic          r_bad, n_bad;
    logic [7:0]    r_hit_count;

    logic [IW-1:0] rd_addr;
    t_rec          rd_data;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_rec          wr_data;
    logic          scan_clr;
    t_scan         flags;
    logic [IW-1:0] hit_idx;
    logic [IW-1:0] cand_idx;
    logic [6:0]    rem;

    function automatic logic [7:0] rd_count_inc(input logic sel);
        logic [7:0] c;
        c = 8'd0;
        if (sel) begin
            c = r_hit_count + 8'd1;
        end
        return c;
    endfunction

    hbc_store #(.NUM_BUFFERS(NUM_BUFFERS), .IW(IW)) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    hbc_scan #(.NUM_BUCKETS(NUM_BUCKETS), .IW(IW)) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (scan_clr),
        .i_en       (r_state == S_SCAN && r_dv),
        .i_idx      (r_didx),
        .i_rec      (rd_data),
        .i_home     (r_home),
        .i_device   (r_req.device),
        .i_block    (r_req.block_number),
        .o_flags    (flags),
        .o_hit_idx  (hit_idx),
        .o_cand_idx (cand_idx)
    );

    always_comb begin
        rem = {1'b0, r_home};
        for (int k = 0; k < REM_BITS; k++) begin
            rem = {rem[5:0], r_shift[31-k]};
            if (rem >= 7'(NUM_BUCKETS)) begin
                rem = rem - 7'(NUM_BUCKETS);
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_busy   = r_busy;
        n_strobe = 1'b0;
        n_rsp    = r_rsp;
        n_req    = r_req;
        n_shift  = r_shift;
        n_home   = r_home;
        n_mcnt   = r_mcnt;
        n_issue  = r_issue;
        n_dv     = r_dv;
        n_didx   = r_didx;
        n_bad    = r_bad;
        rd_addr  = IW'(i_req.buffer_index);
        wr_en    = 1'b0;
        wr_addr  = IW'(r_req.buffer_index);
        wr_data  = rd_data;
        scan_clr = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req  = i_req;
                    n_busy = 1'b1;
                    if (i_req.kind == KIND_GET) begin
                        n_state = S_MOD;
                        n_shift = i_req.block_number;
                        n_home  = '0;
                        n_mcnt  = '0;
                    end else begin
                        n_state = S_RMW;
                        n_bad   = ({4'd0, i_req.buffer_index} >= 9'(NUM_BUFFERS));
                    end
                end
            end
            S_MOD: begin
                n_home  = rem[5:0];
                n_shift = r_shift << REM_BITS;
                n_mcnt  = r_mcnt + 1'b1;
                if (r_mcnt == MW'(REM_STEPS - 1)) begin
                    n_state  = S_SCAN;
                    n_issue  = '0;
                    n_dv     = 1'b0;
                    scan_clr = 1'b1;
                end
            end
            S_SCAN: begin
                rd_addr = r_issue[IW-1:0];
                if (r_issue != CW'(NUM_BUFFERS)) begin
                    n_issue = r_issue + 1'b1;
                    n_dv    = 1'b1;
                    n_didx  = r_issue[IW-1:0];
                end else begin
                    n_dv    = 1'b0;
                    n_state = S_GETW;
                end
            end
            S_GETW: begin
                wr_data = '{device: r_req.device, block: r_req.block_number,
                            home: r_home, count: 8'd1, stamp: r_req.now, cvalid: 1'b1};
                if (flags.hit) begin
                    if (flags.hit_full) begin
                        n_rsp = '{entry: 5'(hit_idx), hit: 1'b1, need_read: 1'b0,
                                  status: ST_RANGE};
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = hit_idx;
                        n_rsp   = '{entry: 5'(hit_idx), hit: 1'b1,
                                    need_read: flags.hit_read, status: ST_OK};
                    end
                end else if (flags.cand) begin
                    wr_en   = 1'b1;
                    wr_addr = cand_idx;
                    n_rsp   = '{entry: 5'(cand_idx), hit: 1'b0, need_read: 1'b1,
                                status: ST_OK};
                end else begin
                    n_rsp = '{entry: 5'd0, hit: 1'b0, need_read: 1'b0, status: ST_NO_BUF};
                end
                if (flags.hit && !flags.hit_full) begin
                    wr_data.count = rd_count_inc(flags.hit);
                end
                n_strobe = 1'b1;
                n_busy   = 1'b0;
                n_state  = S_IDLE;
            end
            S_RMW: begin
                n_rsp = '{entry: r_req.buffer_index, hit: 1'b0, need_read: 1'b0,
                          status: ST_OK};
                if (r_bad) begin
                    n_rsp.status = ST_RANGE;
                end else if (r_req.kind == KIND_PIN) begin
                    if (rd_data.count == COUNT_MAX) begin
                        n_rsp.status = ST_RANGE;
                    end else begin
                        wr_en         = 1'b1;
                        wr_data.count = rd_data.count + 8'd1;
                    end
                end else begin
                    if (rd_data.count == 8'd0) begin
                        n_rsp.status = ST_RANGE;
                    end else begin
                        wr_en         = 1'b1;
                        wr_data.count = rd_data.count - 8'd1;
                        if (r_req.kind == KIND_RELEASE) begin
                            wr_data.stamp = r_req.now;
                        end
                    end
                end
                n_strobe = 1'b1;
                n_busy   = 1'b0;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN && r_dv && !flags.hit) begin
            r_hit_count <= rd_data.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
            r_dv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_busy   <= n_busy;
            r_strobe <= n_strobe;
            r_dv     <= n_dv;
        end
        r_rsp   <= n_rsp;
        r_req   <= n_req;
        r_shift <= n_shift;
        r_home  <= n_home;
        r_mcnt  <= n_mcnt;
        r_issue <= n_issue;
        r_didx  <= n_didx;
        r_bad   <= n_bad;
    end

    assign busy     = r_busy;
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

// File: dv/hashed_block_buffer_cache_tb.sv
// hashed_block_buffer_cache_tb: self-checking bench for the block buffer cache tag manager
// depends on hbc_pkg and hashed_block_buffer_cache; a scoreboard class tracks the
// tag store and compares every result beat against its own prediction
`timescale 1ns / 1ps

module hashed_block_buffer_cache_tb;
    import hbc_pkg::*;

    localparam int NUM_BUFFERS = 32;
    localparam int NUM_BUCKETS = 13;
    localparam int ITEM_TARGET = 1750;
    localparam int CYCLE_LIMIT = 1000000;

    class cache_scoreboard;
        logic [7:0]  dev_tag[NUM_BUFFERS];
        logic [31:0] blk_tag[NUM_BUFFERS];
        logic [5:0]  bucket[NUM_BUFFERS];
        logic [7:0]  refs[NUM_BUFFERS];
        logic [30:0] stamp[NUM_BUFFERS];
        bit          loaded[NUM_BUFFERS];
        t_rsp        pending[$];
        logic [4:0]  last_entry;
        int          errors;

        function new();
            for (int i = 0; i < NUM_BUFFERS; i++) begin
                dev_tag[i] = '0;
                blk_tag[i] = '0;
                bucket[i]  = '0;
                refs[i]    = '0;
                stamp[i]   = '0;
                loaded[i]  = 1'b0;
            end
            last_entry = '0;
            errors = 0;
        endfunction

        function t_rsp apply_request(t_req r);
            t_rsp        rsp;
            int unsigned hb;
            int unsigned b;
            logic [30:0] best;
            int          pick;
            int          idx;
            rsp = '0;
            rsp.entry = r.buffer_index;
            if (r.kind == KIND_GET) begin
                hb = r.block_number % NUM_BUCKETS;
                for (int i = 0; i < NUM_BUFFERS; i++) begin
                    if (bucket[i] == hb && dev_tag[i] == r.device
                            && blk_tag[i] == r.block_number) begin
                        rsp.entry = 5'(i);
                        rsp.hit = 1'b1;
                        if (refs[i] == COUNT_MAX) begin
                            rsp.status = ST_RANGE;
                            return rsp;
                        end
                        refs[i]++;
                        stamp[i] = r.now;
                        rsp.need_read = !loaded[i];
                        loaded[i] = 1'b1;
                        return rsp;
                    end
                end
                for (int k = 0; k < NUM_BUCKETS; k++) begin
                    b = (hb + k) % NUM_BUCKETS;
                    best = STAMP_LIMIT;
                    pick = -1;
                    for (int i = 0; i < NUM_BUFFERS; i++) begin
                        if (bucket[i] == b && refs[i] == 0 && stamp[i] < best) begin
                            best = stamp[i];
                            pick = i;
                        end
                    end
                    if (pick >= 0) begin
                        bucket[pick]  = 6'(hb);
                        stamp[pick]   = r.now;
                        dev_tag[pick] = r.device;
                        blk_tag[pick] = r.block_number;
                        refs[pick]    = 8'd1;
                        loaded[pick]  = 1'b1;
                        rsp.entry = 5'(pick);
                        rsp.need_read = 1'b1;
                        return rsp;
                    end
                end
                rsp.entry = '0;
                rsp.status = ST_NO_BUF;
                return rsp;
            end
            idx = r.buffer_index;
            if (idx >= NUM_BUFFERS) begin
                rsp.status = ST_RANGE;
            end else if (r.kind == KIND_PIN) begin
                if (refs[idx] == COUNT_MAX)
                    rsp.status = ST_RANGE;
                else
                    refs[idx]++;
            end else if (refs[idx] == 0) begin
                rsp.status = ST_RANGE;
            end else begin
                refs[idx]--;
                if (r.kind == KIND_RELEASE)
                    stamp[idx] = r.now;
            end
            return rsp;
        endfunction

        function void note_request(t_req r);
            t_rsp rsp;
            rsp = apply_request(r);
            last_entry = rsp.entry;
            pending.push_back(rsp);
        endfunction

        function void report(string field, int unsigned want, logic [31:0] seen);
            if (seen !== want) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, seen);
                errors++;
            end
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (pending.size() == 0) begin
                $display("%0t: result beat with nothing expected, got %0h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            report("entry", want.entry, got.entry);
            report("hit", want.hit, got.hit);
            report("need_read", want.need_read, got.need_read);
            report("status", want.status, got.status);
        endfunction
    endclass

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    t_req            req;
    logic            strobe;
    t_rsp            rsp;

    cache_scoreboard model;
    int              items_sent;
    int              cycles = 0;
    bit              no_idle;
    logic [30:0]     tick;
    logic [31:0]     blk_pool[16];
    logic [7:0]      dev_pool[4];

    hashed_block_buffer_cache #(
        .NUM_BUFFERS(NUM_BUFFERS),
        .NUM_BUCKETS(NUM_BUCKETS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (req),
        .o_strobe(strobe),
        .o_rsp   (rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && strobe)
            model.check_response(rsp);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL hashed_block_buffer_cache");
            $finish;
        end
    end

    function automatic logic [30:0] next_stamp();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 5)
            return STAMP_LIMIT;
        if (sel < 10)
            return 31'($urandom);
        tick = tick + 31'($urandom_range(0, 3));
        return tick;
    endfunction

    function automatic logic [31:0] pick_block();
        if ($urandom_range(0, 9) < 8)
            return blk_pool[$urandom_range(0, 15)];
        return $urandom;
    endfunction

    function automatic logic [7:0] pick_device();
        if ($urandom_range(0, 9) < 8)
            return dev_pool[$urandom_range(0, 3)];
        return 8'($urandom);
    endfunction

    function automatic t_req make_get(logic [7:0] dev, logic [31:0] blk, logic [30:0] stmp);
        t_req r;
        r.kind = KIND_GET;
        r.device = dev;
        r.block_number = blk;
        r.buffer_index = 5'($urandom);
        r.now = stmp;
        return r;
    endfunction

    function automatic t_req make_op(logic [1:0] kind, logic [4:0] idx, logic [30:0] stmp);
        t_req r;
        r.kind = kind;
        r.device = 8'($urandom);
        r.block_number = $urandom;
        r.buffer_index = idx;
        r.now = stmp;
        return r;
    endfunction

    task automatic send_req(input t_req r);
        int gap;
        int sel;
        sel = $urandom_range(0, 99);
        if (no_idle || sel < 60)
            gap = 0;
        else if (sel < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req <= r;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        model.note_request(r);
        items_sent++;
    endtask

    task automatic drain_refs();
        for (int i = 0; i < NUM_BUFFERS; i++) begin
            while (model.refs[i] != 0)
                send_req(make_op($urandom_range(0, 1) ? KIND_RELEASE : KIND_UNPIN,
                                 5'(i), next_stamp()));
        end
    endtask

    task automatic mixed_round(int n);
        int         sel;
        int         live[$];
        logic [4:0] idx;
        repeat (n) begin
            sel = $urandom_range(0, 99);
            live.delete();
            for (int i = 0; i < NUM_BUFFERS; i++)
                if (model.refs[i] != 0)
                    live.push_back(i);
            if (live.size() != 0 && $urandom_range(0, 9) < 8)
                idx = 5'(live[$urandom_range(0, live.size() - 1)]);
            else
                idx = 5'($urandom);
            if (sel < 45)
                send_req(make_get(pick_device(), pick_block(), next_stamp()));
            else if (sel < 75)
                send_req(make_op(KIND_RELEASE, idx, next_stamp()));
            else if (sel < 87)
                send_req(make_op(KIND_PIN, idx, next_stamp()));
            else
                send_req(make_op(KIND_UNPIN, idx, next_stamp()));
        end
    endtask

    task automatic fill_round();
        repeat (NUM_BUFFERS + 3)
            send_req(make_get(pick_device(), $urandom, next_stamp()));
    endtask

    initial begin
        logic [4:0] sat;
        model = new();
        i_rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        items_sent = 0;
        no_idle = 1'b0;
        tick = '0;
        dev_pool = '{8'h00, 8'h01, 8'h80, 8'hff};
        for (int i = 0; i < 16; i++)
            blk_pool[i] = (i < 8) ? 32'(i * NUM_BUCKETS + i % 3) : $urandom;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // tags match before anything is loaded
        send_req(make_get(8'h00, 32'h0, 31'd5));
        send_req(make_get(8'h00, 32'h0, 31'd6));
        send_req(make_op(KIND_RELEASE, 5'd0, 31'd9));
        send_req(make_op(KIND_UNPIN, 5'd0, 31'd10));
        send_req(make_op(KIND_UNPIN, 5'd0, 31'd11));
        send_req(make_op(KIND_RELEASE, 5'd0, 31'd12));
        send_req(make_op(KIND_PIN, 5'd31, 31'd0));
        send_req(make_op(KIND_UNPIN, 5'd31, 31'd0));
        // miss wraps to bucket 0, oldest stamp with ties to lowest index
        send_req(make_get(8'hff, 32'hffff_ffff, STAMP_LIMIT));
        send_req(make_get(8'hff, 32'hffff_ffff, 31'd0));
        send_req(make_get(8'hfe, 32'hffff_ffff, 31'd0));
        send_req(make_get(8'h00, 32'd13, 31'd1));
        send_req(make_op(KIND_RELEASE, model.last_entry, 31'd0));
        send_req(make_get(8'h00, 32'd13, 31'd2));
        send_req(make_op(KIND_PIN, 5'd1, STAMP_LIMIT));
        send_req(make_get(8'h5a, 32'h1234_5678, 31'h2aaa_aaaa));
        send_req(make_get(8'ha5, 32'hedcb_a987, 31'h5555_5555));
        drain_refs();

        // count saturation on pin and on a get hit
        send_req(make_get(8'h3c, 32'h0000_0d0d, next_stamp()));
        sat = model.last_entry;
        repeat (int'(COUNT_MAX) - 1)
            send_req(make_op(KIND_PIN, sat, next_stamp()));
        send_req(make_op(KIND_PIN, sat, next_stamp()));
        send_req(make_get(8'h3c, 32'h0000_0d0d, next_stamp()));
        drain_refs();

        while (items_sent < ITEM_TARGET) begin
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0)
                fill_round();
            else
                mixed_round($urandom_range(20, 80));
            drain_refs();
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (model.pending.size() != 0)
            @(posedge i_clk);
        repeat (NUM_BUFFERS + 20) @(posedge i_clk);
        if (model.errors == 0 && model.pending.size() == 0)
            $display("PASS hashed_block_buffer_cache");
        else
            $display("FAIL hashed_block_buffer_cache");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/hbc_pkg.sv
hw/rtl/hbc_store.sv
hw/rtl/hbc_scan.sv
hw/rtl/hashed_block_buffer_cache.sv
dv/hashed_block_buffer_cache_tb.sv
